>>> rtl/core/fpr_pkg.sv
// fpr_pkg: shared types and constants of the line rewriter
// holds replacement storage constants, parser state codes, byte codes, the parser action type and byte helpers
// no dependencies
package fpr_pkg;

  // replacement storage
  localparam int unsigned ReplMax    = 56;
  localparam int unsigned NumWords   = 7;
  localparam int unsigned LenW       = 6;
  localparam int unsigned CfgAddrW   = 3;
  localparam logic [CfgAddrW-1:0] CfgLenAddr = 3'd7;

  // parser state codes
  localparam int unsigned StW = 3;
  localparam logic [StW-1:0] StPre  = 3'd0;
  localparam logic [StW-1:0] StF    = 3'd1;
  localparam logic [StW-1:0] StD    = 3'd2;
  localparam logic [StW-1:0] StT    = 3'd3;
  localparam logic [StW-1:0] StGap1 = 3'd4;
  localparam logic [StW-1:0] StGap  = 3'd5;
  localparam logic [StW-1:0] StVal  = 3'd6;
  localparam logic [StW-1:0] StRest = 3'd7;

  // byte codes
  localparam logic [7:0] ChF    = 8'h46;
  localparam logic [7:0] ChD    = 8'h44;
  localparam logic [7:0] ChT    = 8'h54;
  localparam logic [7:0] ChHash = 8'h23;
  localparam logic [7:0] ChNl   = 8'h0A;
  localparam logic [7:0] ChSp   = 8'h20;
  localparam logic [7:0] ChTab  = 8'h09;
  localparam logic [7:0] ChCr   = 8'h0D;
  localparam logic [7:0] ChLowA = 8'h61;
  localparam logic [7:0] ChLowZ = 8'h7A;
  localparam logic [7:0] CaseBit = 8'h20;

  // what one input byte causes
  typedef enum logic [1:0] {
    ActDrop,
    ActCopy,
    ActRepl
  } action_e;

  function automatic logic is_blank(input logic [7:0] c);
    return (c == ChSp) || (c >= ChTab && c <= ChCr);
  endfunction

  function automatic logic [7:0] upcase(input logic [7:0] c);
    return (c >= ChLowA && c <= ChLowZ) ? (c - CaseBit) : c;
  endfunction

endpackage

>>> rtl/core/fdt_path_line_rewriter_top.sv
// fdt_path_line_rewriter_top: byte stream rewriter for FDT keyword lines
// input register, parser, replacement registers and output word register
// depends on fpr_pkg and fpr_parser
// path: an accepted word goes to the input register, then to the output register when it frees
// throughput: one word per cycle while unstalled; a replacement of up to 56 bytes holds the input
// reset: line state returns to line start, replacement words and length clear to zero
module fdt_path_line_rewriter_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input stream, tdata: in_byte[7:0]
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,
  // output stream, tdata: out_byte[7:0]; tlast marks each copied byte and the last replacement byte
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [7:0]                    m_axis_tdata,
  output logic                          m_axis_tlast,
  // configuration write port
  input  logic                          cfg_we_i,
  input  logic [fpr_pkg::CfgAddrW-1:0]  cfg_addr_i,
  input  logic [63:0]                   cfg_wdata_i
);
  import fpr_pkg::*;

  localparam logic [LenW-1:0] ReplMaxL = LenW'(ReplMax);
  localparam logic [CfgAddrW-1:0] NumWordsA = CfgAddrW'(NumWords);

  // configuration registers
  logic [63:0]     repl_q [NumWords];
  logic [LenW-1:0] repl_len_q;
  logic [LenW-1:0] len_sat;

  // input register
  logic            in_valid_q;
  logic [7:0]      in_byte_q;

  // output register
  logic            out_valid_q;
  logic            out_repl_q;
  logic [7:0]      out_byte_q;
  logic [LenW-1:0] out_idx_q;
  logic [LenW-1:0] out_len_q;

  logic            out_last;
  logic            out_done;
  logic            advance;
  logic            step;
  action_e         act;
  logic [63:0]     rd_word;
  logic [7:0]      rd_byte;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumWords; i++) begin
        repl_q[i] <= '0;
      end
      repl_len_q <= '0;
    end else if (cfg_we_i) begin
      if (cfg_addr_i < NumWordsA) begin
        repl_q[cfg_addr_i] <= cfg_wdata_i;
      end else if (cfg_addr_i == CfgLenAddr) begin
        repl_len_q <= cfg_wdata_i[LenW-1:0];
      end
    end
  end

  assign len_sat = (repl_len_q > ReplMaxL) ? ReplMaxL : repl_len_q;

  // handshake control
  assign out_last      = !out_repl_q || ((out_idx_q + 1'b1) == out_len_q);
  assign out_done      = out_valid_q && m_axis_tready && out_last;
  assign advance       = !out_valid_q || out_done;
  assign step          = advance && in_valid_q;
  assign s_axis_tready = !in_valid_q || advance;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q <= s_axis_tdata;
    end
  end

  fpr_parser u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .byte_i (in_byte_q),
    .act_o  (act)
  );

  // output register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_repl_q  <= 1'b0;
      out_idx_q   <= '0;
    end else if (advance) begin
      out_idx_q <= '0;
      if (step && act == ActCopy) begin
        out_valid_q <= 1'b1;
        out_repl_q  <= 1'b0;
      end else if (step && act == ActRepl && len_sat != '0) begin
        out_valid_q <= 1'b1;
        out_repl_q  <= 1'b1;
      end else begin
        out_valid_q <= 1'b0;
        out_repl_q  <= 1'b0;
      end
    end else if (m_axis_tready) begin
      // next byte of the replacement string
      out_idx_q <= out_idx_q + 1'b1;
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (step) begin
      out_byte_q <= in_byte_q;
      out_len_q  <= len_sat;
    end
  end

  // replacement byte select
  assign rd_word = repl_q[out_idx_q[LenW-1:3]];
  assign rd_byte = rd_word[{out_idx_q[2:0], 3'b000} +: 8];

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_repl_q ? rd_byte : out_byte_q;
  assign m_axis_tlast  = out_last;

endmodule

>>> rtl/core/fpr_parser.sv
// fpr_parser: per-line keyword parser, one byte per step
// decides copy, drop or replace for each byte and keeps the line state
// depends on fpr_pkg
module fpr_parser (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   step_i,
  input  logic [7:0]             byte_i,
  output fpr_pkg::action_e       act_o
);
  import fpr_pkg::*;

  logic [StW-1:0] state_q, state_d;
  action_e        act;
  logic           blank;
  logic [7:0]     up;

  assign blank = is_blank(byte_i);
  assign up    = upcase(byte_i);

  // next state and action
  always_comb begin
    state_d = state_q;
    act     = ActCopy;
    case (state_q)
      StPre: begin
        if (blank) begin
          state_d = StPre;
        end else if (byte_i == ChHash) begin
          state_d = StRest;
        end else begin
          state_d = (up == ChF) ? StD : StRest;
        end
      end
      StF: begin
        state_d = (up == ChF) ? StD : StRest;
      end
      StD: begin
        state_d = (up == ChD) ? StT : StRest;
      end
      StT: begin
        state_d = (up == ChT) ? StGap1 : StRest;
      end
      StGap1: begin
        state_d = blank ? StGap : StRest;
      end
      StGap: begin
        if (blank) begin
          state_d = StGap;
        end else if (byte_i == ChHash) begin
          state_d = StRest;
        end else begin
          act     = ActRepl;
          state_d = StVal;
        end
      end
      StVal: begin
        if (blank || byte_i == ChHash) begin
          state_d = StRest;
        end else begin
          act = ActDrop;
        end
      end
      default: begin
        state_d = state_q;
      end
    endcase
    // every newline returns to line start
    if (byte_i == ChNl) begin
      state_d = StPre;
    end
  end

  assign act_o = act;

  // line state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StPre;
    end else if (step_i) begin
      state_q <= state_d;
    end
  end

endmodule

>>> verif/fdt_rewrite_checker.sv
// fdt_rewrite_checker: watches the input, output and configuration ports of the line rewriter
// predicts the rewritten byte stream and compares every output word in order
// depends on fpr_pkg
module fdt_rewrite_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  input  logic                         s_axis_tready,
  input  logic [7:0]                   s_axis_tdata,
  input  logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  input  logic [7:0]                   m_axis_tdata,
  input  logic                         m_axis_tlast,
  input  logic                         cfg_we_i,
  input  logic [fpr_pkg::CfgAddrW-1:0] cfg_addr_i,
  input  logic [63:0]                  cfg_wdata_i,
  output int unsigned                  mismatches_o,
  output int unsigned                  outstanding_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import fpr_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } out_word_t;

  // shadow copy of the configuration and the parser position
  logic [63:0]     repl_words [NumWords];
  logic [LenW-1:0] repl_len_q = '0;
  logic [StW-1:0]  line_st = StPre;

  out_word_t   expected_bytes [$];
  int unsigned fails = 0;

  initial begin
    mismatches_o  = 0;
    outstanding_o = 0;
    foreach (repl_words[i]) repl_words[i] = '0;
  end

  function automatic logic blank_byte(input logic [7:0] c);
    return c == ChSp || c inside {[ChTab:ChCr]};
  endfunction

  function automatic logic [7:0] fold_upper(input logic [7:0] c);
    return c inside {[ChLowA:ChLowZ]} ? c & ~CaseBit : c;
  endfunction

  // works out the output words one input byte causes and advances the line state
  task automatic predict_rewrite(input logic [7:0] c);
    logic [StW-1:0] nxt;
    logic           copy;
    int unsigned    len;
    nxt  = line_st;
    copy = 1'b1;
    case (line_st)
      StPre: begin
        if (c == ChHash) nxt = StRest;
        else if (!blank_byte(c)) nxt = (fold_upper(c) == ChF) ? StD : StRest;
      end
      StF:    nxt = (fold_upper(c) == ChF) ? StD : StRest;
      StD:    nxt = (fold_upper(c) == ChD) ? StT : StRest;
      StT:    nxt = (fold_upper(c) == ChT) ? StGap1 : StRest;
      StGap1: nxt = blank_byte(c) ? StGap : StRest;
      StGap: begin
        if (c == ChHash) begin
          nxt = StRest;
        end else if (!blank_byte(c)) begin
          // first value byte: the replacement string takes its place
          copy = 1'b0;
          len  = (repl_len_q > ReplMax) ? ReplMax : repl_len_q;
          for (int k = 0; k < len; k++)
            expected_bytes.push_back('{data: repl_words[k >> 3][(k & 7) * 8 +: 8],
                                       last: (k + 1 == len)});
          nxt = StVal;
        end
      end
      StVal: begin
        // rest of the value word vanishes until a blank or a hash ends it
        if (blank_byte(c) || c == ChHash) nxt = StRest;
        else copy = 1'b0;
      end
      default: ;
    endcase
    if (copy) expected_bytes.push_back('{data: c, last: 1'b1});
    if (c == ChNl) nxt = StPre;
    line_st = nxt;
  endtask

  always @(posedge clk_i) begin
    out_word_t want;
    if (!rst_ni) begin
      line_st    = StPre;
      repl_len_q = '0;
      foreach (repl_words[i]) repl_words[i] = '0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_addr_i == CfgLenAddr) repl_len_q = cfg_wdata_i[LenW-1:0];
        else repl_words[cfg_addr_i] = cfg_wdata_i;
      end
      if (s_axis_tvalid && s_axis_tready) predict_rewrite(s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_bytes.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("%0t: output word data=%h last=%b with nothing expected",
                     $realtime, m_axis_tdata, m_axis_tlast);
        end else begin
          want = expected_bytes.pop_front();
          if (m_axis_tdata !== want.data || m_axis_tlast !== want.last) begin
            fails++;
            if (fails <= 10)
              $display("%0t: output word wrong: expected data=%h last=%b, got data=%h last=%b",
                       $realtime, want.data, want.last, m_axis_tdata, m_axis_tlast);
          end
        end
      end
    end
    mismatches_o  <= fails;
    outstanding_o <= expected_bytes.size();
  end

endmodule

>>> verif/tb.sv
// tb: stimulus and verdict for the line rewriter
// feeds keyword lines, comments and noise under several replacement settings
// depends on fpr_pkg, fdt_path_line_rewriter_top and fdt_rewrite_checker
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import fpr_pkg::*;

  localparam int unsigned RandomItems  = 310;
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned HoldCycles   = 400;
  localparam logic [7:0]  ChVt = 8'h0B;
  localparam logic [7:0]  ChFf = 8'h0C;

  typedef enum {FillRandom, FillOnes, FillZeros} fill_e;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [7:0]          s_axis_tdata = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [7:0]          m_axis_tdata;
  logic                m_axis_tlast;
  logic                cfg_we_i = 1'b0;
  logic [CfgAddrW-1:0] cfg_addr_i = '0;
  logic [63:0]         cfg_wdata_i = '0;

  int unsigned mismatches;
  int unsigned outstanding;
  int unsigned send_idle_pct = 19;
  int unsigned recv_idle_pct = 66;
  int unsigned hold_reqs = 0;
  int unsigned fed_items = 0;

  always #6 clk_i = ~clk_i;

  fdt_path_line_rewriter_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  fdt_rewrite_checker checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .mismatches_o  (mismatches),
    .outstanding_o (outstanding)
  );

  // offers one word, with random idle cycles ahead of it, and waits for its acceptance
  task automatic push_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    fed_items++;
  endtask

  // waits for the block to drain, then rewrites every register
  task automatic apply_setting(input logic [LenW-1:0] len, input fill_e fill);
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
    repeat (SettleCycles) @(posedge clk_i);
    for (int i = 0; i < NumWords; i++) begin
      cfg_we_i   <= 1'b1;
      cfg_addr_i <= CfgAddrW'(i);
      case (fill)
        FillOnes:  cfg_wdata_i <= '1;
        FillZeros: cfg_wdata_i <= '0;
        default:   cfg_wdata_i <= {$urandom, $urandom};
      endcase
      @(posedge clk_i);
    end
    cfg_addr_i  <= CfgLenAddr;
    cfg_wdata_i <= 64'(len);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // in-line blank, never a newline
  function automatic logic [7:0] pick_blank();
    case ($urandom_range(5))
      0:       return ChTab;
      1:       return ChVt;
      2:       return ChFf;
      3:       return ChCr;
      default: return ChSp;
    endcase
  endfunction

  // any byte that can sit inside a value word
  function automatic logic [7:0] pick_word_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(255));
    while (b == ChSp || b inside {[ChTab:ChCr]} || b == ChHash);
    return b;
  endfunction

  function automatic logic [7:0] letter_case();
    return $urandom_range(1) ? CaseBit : 8'h00;
  endfunction

  // one line of text: mostly keyword lines, some comments, broken keywords and noise
  task automatic random_line();
    int unsigned kind;
    kind = $urandom_range(99);
    repeat ($urandom_range(2)) push_byte(pick_blank());
    if (kind < 70) begin
      push_byte(ChF | letter_case());
      push_byte(ChD | letter_case());
      push_byte(ChT | letter_case());
      repeat ($urandom_range(1, 3)) push_byte(pick_blank());
      if ($urandom_range(9) == 0) begin
        push_byte(ChHash);
      end else begin
        push_byte(pick_word_byte());
        // trailing value bytes are dropped by the block
        repeat ($urandom_range(5)) push_byte(pick_word_byte());
        case ($urandom_range(3))
          0:       ;
          1:       push_byte(ChHash);
          default: push_byte(pick_blank());
        endcase
      end
      repeat ($urandom_range(4)) push_byte(8'($urandom_range(255)));
    end else if (kind < 80) begin
      push_byte(ChHash);
      repeat ($urandom_range(5)) push_byte(8'($urandom_range(255)));
    end else if (kind < 90) begin
      // keyword cut short or glued to the next word
      push_byte(ChF | letter_case());
      if ($urandom_range(1)) push_byte(ChD | letter_case());
      if ($urandom_range(1)) push_byte(ChT | letter_case());
      push_byte(pick_word_byte());
      repeat ($urandom_range(3)) push_byte(8'($urandom_range(255)));
    end else begin
      repeat ($urandom_range(1, 8)) push_byte(8'($urandom_range(255)));
    end
    push_byte(ChNl);
  endtask

  // receiver: random stalls, or a long hold-off when one is requested
  initial begin
    int unsigned hold_left;
    int unsigned seen_reqs;
    hold_left = 0;
    seen_reqs = 0;
    forever begin
      @(posedge clk_i);
      if (hold_reqs != seen_reqs) begin
        seen_reqs = hold_reqs;
        hold_left = HoldCycles;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // main sequence
  initial begin
    logic [7:0] opening_text [$];
    opening_text = '{
      ChTab, "f", "D", "t", ChSp, 8'hFF, 8'h00, ChSp, ChHash, ChNl,
      "F", "D", "T", "d", ChNl,
      "F", "D", "T", ChSp, ChHash, ChNl,
      "F", "D", "T", ChTab, ChNl,
      ChSp, ChHash, ChNl
    };
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed lines with an oversized length that must saturate
    apply_setting(6'd63, FillRandom);
    foreach (opening_text[i]) push_byte(opening_text[i]);

    for (int ph = 0; ph < 6; ph++) begin
      if (ph < 2) begin
        send_idle_pct = 19;
        recv_idle_pct = 66;
      end else if (ph < 4) begin
        send_idle_pct = 66;
        recv_idle_pct = 19;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case (ph)
        0:       apply_setting(6'd0, FillRandom);
        1:       apply_setting(LenW'(ReplMax), FillOnes);
        2:       apply_setting(6'd1, FillZeros);
        3:       apply_setting(LenW'($urandom_range(63)), FillRandom);
        4:       apply_setting(LenW'(ReplMax), FillRandom);
        default: apply_setting(LenW'($urandom_range(2, 20)), FillRandom);
      endcase
      // long output stall while the input keeps pushing
      if (ph == 4) hold_reqs++;
      while (fed_items < (ph + 1) * RandomItems / 6) random_line();
    end

    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && outstanding == 0)
      $display("fdt_path_line_rewriter_top: match");
    else
      $display("fdt_path_line_rewriter_top: mismatch");
    $finish;
  end

  // watchdog
  initial begin
    #10_000_000;
    $display("fdt_path_line_rewriter_top: mismatch");
    $finish;
  end

endmodule

>>> sim.f
rtl/core/fpr_pkg.sv
rtl/core/fpr_parser.sv
rtl/core/fdt_path_line_rewriter_top.sv
verif/fdt_rewrite_checker.sv
verif/tb.sv
